### rtl/k2ls_pkg.sv
// Package for the K2 local score engine.
// Holds the row and result word types, register indexes and state types.
// No dependencies; every other file imports it.
package k2ls_pkg;

  // Widths fixed by the word layout.
  localparam int VAL_W      = 3;
  localparam int ARITY_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int SCORE_W    = 48;
  localparam int ROWS_W     = 13;

  // ln 2 in unsigned Q32.
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PARENT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARITY_A      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARITY_B      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ARITY_C      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHILD_ARITY  = 3'd4;

  // One data row.
  typedef struct packed {
    logic [VAL_W-1:0] parent_value_a;
    logic [VAL_W-1:0] parent_value_b;
    logic [VAL_W-1:0] parent_value_c;
    logic [VAL_W-1:0] child_value;
    logic             last_row;
  } row_word_t;

  // One score result.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score_value;
    logic [ROWS_W-1:0]         rows_counted;
    logic                      bad_value_seen;
    logic                      row_overflow;
  } score_word_t;

  // Main sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PREP,
    ST_WALK,
    ST_FINISH
  } eng_state_t;

  // Log-factorial table builder states.
  typedef enum logic [2:0] {
    BS_ZERO,
    BS_SETUP,
    BS_ITER,
    BS_ACC,
    BS_MUL_HI,
    BS_MUL_LO,
    BS_WRITE,
    BS_DONE
  } build_state_t;

endpackage

### rtl/k2ls_lf_rom.sv
// Log-factorial table: a memory of ln(k!) values in fixed point, two read ports.
// After reset it fills itself, one entry at a time, then raises ready.
// Depends on k2ls_pkg.
module k2ls_lf_rom #(
  parameter int MAX_ROWS  = 4096,
  parameter int MAX_ARITY = 8,
  parameter int FRAC_BITS = 16,
  localparam int DEPTH = MAX_ROWS + MAX_ARITY + 1,
  localparam int AW    = $clog2(DEPTH),
  localparam int HI_W  = AW + 6,
  localparam int LF_W  = HI_W + FRAC_BITS
) (
  input  logic            clk,
  input  logic            rst,
  output logic            ready,
  input  logic [AW-1:0]   addr_a,
  output logic [LF_W-1:0] data_a,
  input  logic [AW-1:0]   addr_b,
  output logic [LF_W-1:0] data_b
);
  import k2ls_pkg::*;

  localparam int EW  = $clog2(AW + 1);
  localparam int ACW = HI_W + 32;
  localparam logic [ACW-1:0] HALF = ACW'(1) << (31 - FRAC_BITS);

  logic [LF_W-1:0] mem [DEPTH];

  build_state_t    state, state_next;
  logic [AW-1:0]   k;
  logic [AW:0]     k_inc;
  logic [EW-1:0]   e;
  logic [31:0]     x;
  logic [31:0]     frac;
  logic [4:0]      bit_idx;
  logic [ACW-1:0]  acc;
  logic [ACW-1:0]  p_hi;
  logic [63:0]     p_lo;
  logic [63:0]     sq;
  logic [32:0]     sq_sh;
  logic [ACW-1:0]  lnq;
  logic [ACW-1:0]  rnd;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [LF_W-1:0] wr_data;

  // Squaring step of the mantissa and the final rounding.
  always_comb begin
    sq      = 64'(x) * 64'(x);
    sq_sh   = sq[63:31];
    k_inc   = {1'b0, k} + (AW+1)'(1);
    lnq     = p_hi + ACW'(p_lo[63:32]);
    rnd     = lnq + HALF;
    wr_en   = (state == BS_ZERO) || (state == BS_WRITE);
    wr_addr = (state == BS_ZERO) ? '0 : k;
    wr_data = (state == BS_ZERO) ? '0 : rnd[32-FRAC_BITS +: LF_W];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_ZERO;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BS_ZERO:   state_next = BS_SETUP;
      BS_SETUP:  state_next = BS_ITER;
      BS_ITER:   if (bit_idx == 5'd0) state_next = BS_ACC;
      BS_ACC:    state_next = BS_MUL_HI;
      BS_MUL_HI: state_next = BS_MUL_LO;
      BS_MUL_LO: state_next = BS_WRITE;
      BS_WRITE:  if (k == AW'(DEPTH - 1)) state_next = BS_DONE;
                 else state_next = BS_SETUP;
      BS_DONE:   state_next = BS_DONE;
      default:   state_next = BS_DONE;
    endcase
  end

  assign ready = (state == BS_DONE);

  // Builder datapath: log2 of k by repeated squaring, running sum, times ln 2.
  always_ff @(posedge clk) begin
    if (rst) begin
      k   <= AW'(1);
      e   <= '0;
      acc <= '0;
    end else begin
      unique case (state)
        BS_SETUP: begin
          x       <= 32'(k) << (5'd31 - 5'(e));
          frac    <= '0;
          bit_idx <= 5'd31;
        end
        BS_ITER: begin
          if (sq_sh[32]) begin
            x             <= sq_sh[32:1];
            frac[bit_idx] <= 1'b1;
          end else begin
            x <= sq_sh[31:0];
          end
          bit_idx <= bit_idx - 5'd1;
        end
        BS_ACC:    acc  <= acc + {HI_W'(e), frac};
        BS_MUL_HI: p_hi <= ACW'(acc[ACW-1:32]) * ACW'(LN2_Q32);
        BS_MUL_LO: p_lo <= 64'(acc[31:0]) * 64'(LN2_Q32);
        BS_WRITE: begin
          k <= k_inc[AW-1:0];
          if ((k_inc >> (e + EW'(1))) != '0) e <= e + EW'(1);
        end
        default: ;
      endcase
    end
  end

  // Table memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    data_a <= mem[addr_a];
    data_b <= mem[addr_b];
  end

endmodule

### rtl/k2_local_score_engine.sv
// Top level of the K2 local score engine: row counting and score walk.
// Depends on k2ls_pkg and k2ls_lf_rom.
//
// Channel  | Direction | Handshake           | Word
// row      | in        | row_valid/row_stall | row_word_t (values, last_row)
// score    | out       | score_valid/score_stall | score_word_t (score, rows, flags)
// cfg      | in        | cfg_write_en        | cfg_index, cfg_data
//
// A row word is taken every cycle while the engine is idle; counting is a
// read-modify-write of the count memory with forwarding of the previous write.
// A last row starts a walk over all MAX_ARITY**4 count entries, one per cycle,
// which also clears them. After reset, rows are stalled while the log-factorial
// table builds its MAX_ROWS + MAX_ARITY + 1 entries; the count memory is
// cleared alongside.
module k2_local_score_engine #(
  parameter int MAX_PARENTS = 3,
  parameter int MAX_ARITY   = 8,
  parameter int MAX_ROWS    = 4096,
  parameter int FRAC_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            row_valid,
  output logic                            row_stall,
  input  k2ls_pkg::row_word_t             row_word,
  output logic                            score_valid,
  input  logic                            score_stall,
  output k2ls_pkg::score_word_t           score_word,
  input  logic                            cfg_write_en,
  input  logic [k2ls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [k2ls_pkg::CFG_DATA_W-1:0] cfg_data
);
  import k2ls_pkg::*;

  localparam int LF_DEPTH = MAX_ROWS + MAX_ARITY + 1;
  localparam int LAW      = $clog2(LF_DEPTH);
  localparam int HI_W     = LAW + 6;
  localparam int LF_W     = HI_W + FRAC_BITS;
  localparam int DW       = $clog2(MAX_ARITY);
  localparam int C_DEPTH  = MAX_ARITY ** 4;
  localparam int CW       = $clog2(C_DEPTH);
  localparam int RCW      = $clog2(MAX_ROWS + 1);
  localparam int SW       = (LF_W + 18 > SCORE_W + 1) ? LF_W + 18 : SCORE_W + 1;
  localparam logic signed [SW-1:0] S_MAX = {{(SW-SCORE_W+1){1'b0}}, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = ~S_MAX;
  localparam logic [DW-1:0] DIG_MAX = DW'(MAX_ARITY - 1);

  function automatic logic [4:0] eff_arity(input logic [ARITY_W-1:0] a);
    logic [4:0] r;
    if (a == '0) r = 5'd1;
    else if (5'(a) > 5'(MAX_ARITY)) r = 5'(MAX_ARITY);
    else r = 5'(a);
    return r;
  endfunction

  function automatic logic [CW-1:0] cell_addr(input logic [CW-1:0] dk, input logic [CW-1:0] da,
                                              input logic [CW-1:0] db, input logic [CW-1:0] dc);
    logic [CW-1:0] m;
    m = CW'(MAX_ARITY);
    return dk + m * (da + m * (db + m * dc));
  endfunction

  // Configuration registers.
  logic [1:0]         cfg_parent_count;
  logic [ARITY_W-1:0] cfg_arity_a, cfg_arity_b, cfg_arity_c, cfg_child_arity;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_parent_count <= '0;
      cfg_arity_a      <= ARITY_W'(1);
      cfg_arity_b      <= ARITY_W'(1);
      cfg_arity_c      <= ARITY_W'(1);
      cfg_child_arity  <= ARITY_W'(1);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_PARENT_COUNT: cfg_parent_count <= cfg_data[1:0];
        REG_ARITY_A:      cfg_arity_a      <= cfg_data;
        REG_ARITY_B:      cfg_arity_b      <= cfg_data;
        REG_ARITY_C:      cfg_arity_c      <= cfg_data;
        REG_CHILD_ARITY:  cfg_child_arity  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective arities of the parents in use and of the child.
  logic [1:0] n_par;
  logic [4:0] na, nb, nc, r;

  always_comb begin
    n_par = (32'(cfg_parent_count) > MAX_PARENTS) ? 2'(MAX_PARENTS) : cfg_parent_count;
    na    = (n_par >= 2'd1) ? eff_arity(cfg_arity_a) : 5'd1;
    nb    = (n_par >= 2'd2) ? eff_arity(cfg_arity_b) : 5'd1;
    nc    = (n_par >= 2'd3) ? eff_arity(cfg_arity_c) : 5'd1;
    r     = eff_arity(cfg_child_arity);
  end

  eng_state_t state, state_next;
  logic       rom_ready;
  logic       clr_done;
  logic       walk_end;
  logic       s1_valid, s2_val_a, s2_val_b;
  logic       out_free;

  assign row_stall = (state != ST_IDLE);
  assign out_free  = !score_valid || !score_stall;

  logic row_accept;
  assign row_accept = row_valid && !row_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:   if (clr_done && rom_ready) state_next = ST_IDLE;
      ST_IDLE:   if (row_accept && row_word.last_row) state_next = ST_PREP;
      ST_PREP:   state_next = ST_WALK;
      ST_WALK:   if (walk_end) state_next = ST_FINISH;
      ST_FINISH: if (!s1_valid && !s2_val_a && !s2_val_b && out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Row counter, flags and their snapshot for the result.
  logic [RCW-1:0] row_counter, res_rows;
  logic           bad_flag, ovf_flag, res_bad, res_ovf;

  // Row checks and the count address of this row.
  logic [2:0]    va, vb, vc;
  logic          row_bad, row_room, row_counted;
  logic [CW-1:0] row_addr;

  always_comb begin
    va       = (n_par >= 2'd1) ? row_word.parent_value_a : 3'd0;
    vb       = (n_par >= 2'd2) ? row_word.parent_value_b : 3'd0;
    vc       = (n_par >= 2'd3) ? row_word.parent_value_c : 3'd0;
    row_bad  = (5'(row_word.child_value) >= r) || (5'(va) >= na) ||
               (5'(vb) >= nb) || (5'(vc) >= nc);
    row_room = (row_counter < RCW'(MAX_ROWS));
    row_counted = !row_bad && row_room;
    row_addr = cell_addr(CW'(row_word.child_value), CW'(va), CW'(vb), CW'(vc));
  end

  // Row counter and flags; snapshot into the result on the last row.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      bad_flag    <= 1'b0;
      ovf_flag    <= 1'b0;
    end else if (row_accept) begin
      if (row_word.last_row) begin
        row_counter <= '0;
        bad_flag    <= 1'b0;
        ovf_flag    <= 1'b0;
      end else begin
        row_counter <= row_counted ? row_counter + RCW'(1) : row_counter;
        bad_flag    <= bad_flag | row_bad;
        ovf_flag    <= ovf_flag | (!row_bad && !row_room);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_accept && row_word.last_row) begin
      res_rows <= row_counted ? row_counter + RCW'(1) : row_counter;
      res_bad  <= bad_flag | row_bad;
      res_ovf  <= ovf_flag | (!row_bad && !row_room);
    end
  end

  // Walk counters, child value fastest.
  logic [DW-1:0] wk, wa, wb, wc;
  logic [CW-1:0] walk_addr;
  logic          w_in, w_combo;

  always_comb begin
    walk_addr = cell_addr(CW'(wk), CW'(wa), CW'(wb), CW'(wc));
    w_combo   = (5'(wa) < na) && (5'(wb) < nb) && (5'(wc) < nc);
    w_in      = w_combo && (5'(wk) < r);
    walk_end  = (wk == DIG_MAX) && (wa == DIG_MAX) && (wb == DIG_MAX) && (wc == DIG_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst || state == ST_PREP) begin
      wk <= '0;
      wa <= '0;
      wb <= '0;
      wc <= '0;
    end else if (state == ST_WALK) begin
      if (wk != DIG_MAX) begin
        wk <= wk + DW'(1);
      end else begin
        wk <= '0;
        if (wa != DIG_MAX) begin
          wa <= wa + DW'(1);
        end else begin
          wa <= '0;
          if (wb != DIG_MAX) begin
            wb <= wb + DW'(1);
          end else begin
            wb <= '0;
            wc <= wc + DW'(1);
          end
        end
      end
    end
  end

  // Clearing sweep of the count memory after reset.
  logic [CW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_done <= 1'b0;
    end else if (!clr_done) begin
      clr_addr <= clr_addr + CW'(1);
      if (clr_addr == CW'(C_DEPTH - 1)) clr_done <= 1'b1;
    end
  end

  // Count update stage with forwarding of the previous write.
  logic           p1_valid, wq_valid;
  logic [CW-1:0]  p1_addr, wq_addr;
  logic [RCW-1:0] wq_data, p1_new, cell_rd;

  assign p1_new = ((wq_valid && wq_addr == p1_addr) ? wq_data : cell_rd) + RCW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      wq_valid <= 1'b0;
    end else begin
      p1_valid <= row_accept && row_counted;
      wq_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_addr <= row_addr;
    wq_addr <= p1_addr;
    wq_data <= p1_new;
  end

  // Count memory ports.
  logic [RCW-1:0] cell_mem [C_DEPTH];
  logic           cw_en;
  logic [CW-1:0]  cw_addr, cr_addr;
  logic [RCW-1:0] cw_data;

  always_comb begin
    cr_addr = (state == ST_WALK) ? walk_addr : row_addr;
    priority if (state == ST_INIT) begin
      cw_en   = !clr_done;
      cw_addr = clr_addr;
      cw_data = '0;
    end else if (state == ST_WALK) begin
      cw_en   = 1'b1;
      cw_addr = walk_addr;
      cw_data = '0;
    end else begin
      cw_en   = p1_valid;
      cw_addr = p1_addr;
      cw_data = p1_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cw_en) cell_mem[cw_addr] <= cw_data;
    cell_rd <= cell_mem[cr_addr];
  end

  // Log-factorial table.
  logic [LAW-1:0]  lf_addr_a, lf_addr_b;
  logic [LF_W-1:0] lf_data_a, lf_data_b;

  k2ls_lf_rom #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_ARITY (MAX_ARITY),
    .FRAC_BITS (FRAC_BITS)
  ) u_lf_rom (
    .clk    (clk),
    .rst    (rst),
    .ready  (rom_ready),
    .addr_a (lf_addr_a),
    .data_a (lf_data_a),
    .addr_b (lf_addr_b),
    .data_b (lf_data_b)
  );

  // Walk stage one: count word arrives, table lookups are issued.
  logic           s1_in, s1_grp, s1_combo;
  logic [RCW-1:0] n_acc, n_tot;

  always_comb begin
    n_tot     = n_acc + (s1_in ? cell_rd : RCW'(0));
    lf_addr_a = LAW'(cell_rd);
    lf_addr_b = (state == ST_PREP) ? LAW'(r - 5'd1)
                                   : LAW'(n_tot) + LAW'(r) - LAW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_val_a <= 1'b0;
      s2_val_b <= 1'b0;
    end else begin
      s1_valid <= (state == ST_WALK);
      s2_val_a <= s1_valid && s1_in && (cell_rd != '0);
      s2_val_b <= s1_valid && s1_grp && s1_combo && (n_tot != '0);
    end
  end

  always_ff @(posedge clk) begin
    s1_in    <= w_in;
    s1_grp   <= (wk == DIG_MAX);
    s1_combo <= w_combo;
    if (state == ST_PREP) n_acc <= '0;
    else if (s1_valid) n_acc <= s1_grp ? RCW'(0) : n_tot;
  end

  // Walk stage two: score accumulation.
  logic                   prep_q;
  logic [LF_W-1:0]        lf_r;
  logic signed [SW-1:0]   score, term_a, term_b, score_sat;

  always_comb begin
    term_a = s2_val_a ? $signed({{(SW-LF_W){1'b0}}, lf_data_a}) : '0;
    term_b = s2_val_b ? ($signed({{(SW-LF_W){1'b0}}, lf_r}) -
                         $signed({{(SW-LF_W){1'b0}}, lf_data_b})) : '0;
    if (score > S_MAX) score_sat = S_MAX;
    else if (score < S_MIN) score_sat = S_MIN;
    else score_sat = score;
  end

  always_ff @(posedge clk) begin
    prep_q <= (state == ST_PREP);
    if (prep_q) lf_r <= lf_data_b;
    if (state == ST_PREP) score <= '0;
    else score <= score + term_a + term_b;
  end

  // Output register.
  logic score_load;
  assign score_load = (state == ST_FINISH) && (state_next == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      score_valid <= 1'b0;
    end else if (score_load) begin
      score_valid <= 1'b1;
    end else if (!score_stall) begin
      score_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (score_load) begin
      score_word.score_value    <= score_sat[SCORE_W-1:0];
      score_word.rows_counted   <= ROWS_W'(res_rows);
      score_word.bad_value_seen <= res_bad;
      score_word.row_overflow   <= res_ovf;
    end
  end

endmodule
